// ----- src/tlqe_pkg.sv -----
package tlqe_pkg;

  localparam int unsigned CoordW = 24;
  localparam int unsigned DiffW  = 25;
  localparam int unsigned WidthW = 16;
  localparam int unsigned ColorW = 32;
  localparam int unsigned CountW = 32;
  // Squared length: two 24-bit magnitudes squared and summed, 50 bits.
  localparam int unsigned SqW    = 50;
  // The root operand carries 14 extra fraction bits: 64 bits.
  localparam int unsigned RadW   = 64;
  localparam int unsigned RootW  = 32;
  // Numerator magnitude |d| * w * 64 is 24 + 16 + 6 = 46 bits; adding half the
  // divisor for rounding can carry into one more bit, so 47 bits.
  localparam int unsigned NumW   = 47;
  localparam int unsigned QuoW   = 47;

  // Sequencer state codes.
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StSq   = 3'd1;
  localparam logic [2:0] StRoot = 3'd2;
  localparam logic [2:0] StDiv  = 3'd3;
  localparam logic [2:0] StEmit = 3'd4;

  typedef struct packed {
    logic [CoordW-1:0] start_x;
    logic [CoordW-1:0] start_y;
    logic [CoordW-1:0] end_x;
    logic [CoordW-1:0] end_y;
    logic [WidthW-1:0] line_width;
    logic [ColorW-1:0] packed_color;
  } seg_t;

  typedef struct packed {
    logic [CoordW-1:0] vert_x;
    logic [CoordW-1:0] vert_y;
    logic [ColorW-1:0] vert_color;
    logic [CountW-1:0] vertex_number;
    logic [1:0]        corner;
    logic              last_corner;
  } vert_t;

  // Serial unit handshake.
  typedef struct packed {
    logic start;
  } unit_req_t;

  typedef struct packed {
    logic done;
  } unit_rsp_t;

endpackage

// ----- src/tlqe_if.sv -----
interface tlqe_seg_if;
  import tlqe_pkg::*;
  logic valid;
  logic ready;
  seg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tlqe_vert_if;
  import tlqe_pkg::*;
  logic  valid;
  logic  ready;
  vert_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/thick_line_quad_expander.sv -----
// Expands one line segment into four quad corners: start+n, end+n, end-n, start-n,
// where n is the unit normal scaled by half the thickness. A segment is accepted,
// its deltas are formed and squared, then it passes the bit-serial square root
// and the bit-serial divider, run twice (once per normal component), and then
// its four corner beats go out as the output takes them. A segment with
// identical endpoints produces no beats and returns to idle after the squaring
// step. The next segment is accepted once the last corner of the current one
// has been handed to the output register.
module thick_line_quad_expander import tlqe_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  tlqe_seg_if.sink     seg_i,
  tlqe_vert_if.source  vert_o
);

  logic [2:0]        state_q, state_d;
  seg_t              seg_q;
  logic [DiffW-1:0]  dx_q, dy_q;
  logic [RootW-1:0]  len_q;
  logic              phase_q;
  logic [1:0]        k_q;
  logic [CountW-1:0] total_q;
  logic              ov_q;
  vert_t             ov_data_q;
  logic [DiffW+1:0]  nx_q, ny_q;

  logic              acc_in, acc_out, out_free;
  logic [DiffW-1:0]  dx_w, dy_w, adx, ady, dsel;
  logic [SqW-1:0]    sq_w;
  logic [NumW-1:0]   num_w;
  logic              neg_w;
  unit_req_t         sq_req, dv_req;
  unit_rsp_t         sq_rsp, dv_rsp;
  logic [RootW-1:0]  root_w;
  logic [QuoW-1:0]   quo_w;
  logic [DiffW+1:0]  qsig;
  logic [DiffW+2:0]  px, py;
  logic [DiffW+1:0]  bx, by, ex, ey;

  function automatic logic [CoordW-1:0] sat(input logic [DiffW+2:0] v);
    logic [CoordW-1:0] r;
    if ($signed(v) > $signed((DiffW+3)'(24'h7fffff))) r = 24'h7fffff;
    else if ($signed(v) < -$signed((DiffW+3)'(24'h800000))) r = 24'h800000;
    else r = v[CoordW-1:0];
    return r;
  endfunction

  assign acc_in   = seg_i.valid && seg_i.ready;
  assign acc_out  = vert_o.valid && vert_o.ready;
  assign out_free = !ov_q || vert_o.ready;
  assign seg_i.ready = (state_q == StIdle);

  assign dx_w = DiffW'($signed(seg_q.end_x)) - DiffW'($signed(seg_q.start_x));
  assign dy_w = DiffW'($signed(seg_q.end_y)) - DiffW'($signed(seg_q.start_y));
  assign adx  = dx_q[DiffW-1] ? -dx_q : dx_q;
  assign ady  = dy_q[DiffW-1] ? -dy_q : dy_q;

  // Numerator for the division being started: |dy| for nx when the first one
  // starts out of the root step, |dx| for ny when the second one starts.
  // The sign is applied on capture: -dy for nx, dx for ny.
  assign dsel  = (state_q == StDiv) ? adx : ady;
  assign neg_w = phase_q ? dx_q[DiffW-1] : !dy_q[DiffW-1] && (dy_q != '0);
  assign num_w = (NumW'(dsel[CoordW-1:0]) * NumW'(seg_q.line_width)) << 6;

  // Squared length from the registered deltas, fed straight into the root.
  assign sq_w = SqW'(adx * adx) + SqW'(ady * ady);
  assign sq_req.start = (state_q == StSq) && phase_q && (sq_w != '0);
  always_comb begin
    dv_req.start = 1'b0;
    if (state_q == StRoot && sq_rsp.done) dv_req.start = 1'b1;
    if (state_q == StDiv && dv_rsp.done && !phase_q) dv_req.start = 1'b1;
  end

  tlqe_sqrt u_sqrt (
    .clk_i, .rst_ni, .req_i(sq_req), .rad_i({sq_w, 14'b0}),
    .rsp_o(sq_rsp), .root_o(root_w)
  );

  tlqe_div u_div (
    .clk_i, .rst_ni, .req_i(dv_req), .num_i(num_w),
    .den_i(state_q == StRoot ? root_w : len_q), .rsp_o(dv_rsp), .quo_o(quo_w)
  );

  // Quotient magnitude (unsigned); it fits easily in 26 bits and is clamped there.
  assign qsig = (|quo_w[QuoW-1:DiffW+1]) ? {1'b0, {(DiffW+1){1'b1}}} : quo_w[DiffW+1:0];

  // Corner arithmetic.
  assign bx = (DiffW+2)'($signed(seg_q.start_x));
  assign by = (DiffW+2)'($signed(seg_q.start_y));
  assign ex = (DiffW+2)'($signed(seg_q.end_x));
  assign ey = (DiffW+2)'($signed(seg_q.end_y));
  always_comb begin
    case (k_q)
      2'd0: begin px = {bx[DiffW+1], bx} + {nx_q[DiffW+1], nx_q};
                  py = {by[DiffW+1], by} + {ny_q[DiffW+1], ny_q}; end
      2'd1: begin px = {ex[DiffW+1], ex} + {nx_q[DiffW+1], nx_q};
                  py = {ey[DiffW+1], ey} + {ny_q[DiffW+1], ny_q}; end
      2'd2: begin px = {ex[DiffW+1], ex} - {nx_q[DiffW+1], nx_q};
                  py = {ey[DiffW+1], ey} - {ny_q[DiffW+1], ny_q}; end
      default: begin px = {bx[DiffW+1], bx} - {nx_q[DiffW+1], nx_q};
                     py = {by[DiffW+1], by} - {ny_q[DiffW+1], ny_q}; end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (acc_in) state_d = StSq;
      StSq: if (phase_q) state_d = (sq_w == '0) ? StIdle : StRoot;
      StRoot: if (sq_rsp.done) state_d = StDiv;
      StDiv: if (dv_rsp.done && phase_q) state_d = StEmit;
      StEmit: if (out_free && k_q == 2'd3) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      phase_q <= 1'b0;
      k_q     <= '0;
      total_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      // The output register fills on each corner and drains on a taken beat.
      if (state_q == StEmit && out_free) ov_q <= 1'b1;
      else if (acc_out) ov_q <= 1'b0;
      case (state_q)
        StIdle: phase_q <= 1'b0;
        StSq: phase_q <= ~phase_q;
        StRoot: phase_q <= 1'b0;
        StDiv: if (dv_rsp.done) phase_q <= ~phase_q;
        StEmit: if (out_free) begin
          k_q     <= k_q + 2'd1;
          total_q <= total_q + CountW'(1);
        end
        default: phase_q <= 1'b0;
      endcase
    end
  end

  // Payload path.
  always_ff @(posedge clk_i) begin
    if (acc_in) seg_q <= seg_i.data;
    if (state_q == StSq && !phase_q) begin
      dx_q <= dx_w;
      dy_q <= dy_w;
    end
    if (state_q == StRoot && sq_rsp.done) len_q <= root_w;
    if (state_q == StDiv && dv_rsp.done) begin
      if (!phase_q) nx_q <= neg_w ? -qsig : qsig;
      else          ny_q <= neg_w ? -qsig : qsig;
    end
    if (state_q == StEmit && out_free) begin
      ov_data_q.vert_x        <= sat(px);
      ov_data_q.vert_y        <= sat(py);
      ov_data_q.vert_color    <= seg_q.packed_color;
      ov_data_q.vertex_number <= total_q;
      ov_data_q.corner        <= k_q;
      ov_data_q.last_corner   <= (k_q == 2'd3);
    end
  end

  assign vert_o.valid = ov_q;
  assign vert_o.data  = ov_data_q;

  // A segment is only taken while the sequencer is idle.
  a_in_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_in |-> state_q == StIdle) else $error("segment taken while busy");

  // The corner index tracks the low bits of the vertex count.
  a_k_tot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    k_q == total_q[1:0]) else $error("corner index out of step");

  // Each emitted beat marks last exactly on corner three.
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vert_o.valid |-> vert_o.data.last_corner == (vert_o.data.corner == 2'd3))
    else $error("last corner flag wrong");

endmodule

// ----- src/tlqe_sqrt.sv -----
// Restoring square root, two radicand bits per cycle, one root bit per cycle.
module tlqe_sqrt import tlqe_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  unit_req_t        req_i,
  input  logic [RadW-1:0]  rad_i,
  output unit_rsp_t        rsp_o,
  output logic [RootW-1:0] root_o
);

  logic [RadW-1:0]  rad_q, rad_d;
  logic [RootW+1:0] rem_q, rem_d;
  logic [RootW-1:0] root_q, root_d;
  logic [5:0]       cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic [RootW+1:0] trial;
  logic [RootW+1:0] rem_sh;

  always_comb begin
    rem_sh = {rem_q[RootW-1:0], rad_q[RadW-1:RadW-2]};
    trial  = rem_sh - {root_q, 2'b01};
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (req_i.start) begin
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = 6'(RootW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = {rad_q[RadW-3:0], 2'b00};
      if (!trial[RootW+1]) begin
        rem_d  = trial;
        root_d = {root_q[RootW-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[RootW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  // The root includes the bit decided in the current step, so it is complete
  // in the cycle that done is high.
  assign rsp_o.done = busy_q && (cnt_q == 6'd1);
  assign root_o     = {root_q[RootW-2:0], !trial[RootW+1]};

endmodule

// ----- src/tlqe_div.sv -----
// Restoring divider, one quotient bit per cycle, rounds half away from zero.
module tlqe_div import tlqe_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  unit_req_t        req_i,
  input  logic [NumW-1:0]  num_i,
  input  logic [RootW-1:0] den_i,
  output unit_rsp_t        rsp_o,
  output logic [QuoW-1:0]  quo_o
);

  logic [NumW-1:0]  num_q, num_d;
  logic [RootW:0]   rem_q, rem_d;
  logic [RootW-1:0] den_q, den_d;
  logic [QuoW-1:0]  quo_q, quo_d;
  logic [5:0]       cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic [RootW:0]   rem_sh;
  logic [RootW:0]   trial;

  always_comb begin
    rem_sh = {rem_q[RootW-1:0], num_q[NumW-1]};
    trial  = rem_sh - {1'b0, den_q};
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (req_i.start) begin
      // Adding den/2 to the numerator gives round half up on the magnitude.
      num_d  = num_i + NumW'(den_i >> 1);
      den_d  = den_i;
      rem_d  = '0;
      quo_d  = '0;
      cnt_d  = 6'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[NumW-2:0], 1'b0};
      if (!trial[RootW]) begin
        rem_d = trial;
        quo_d = {quo_q[QuoW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[QuoW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  // The quotient includes the bit decided in the current step, so it is
  // complete in the cycle that done is high, even if a new start arrives.
  assign rsp_o.done = busy_q && (cnt_q == 6'd1);
  assign quo_o      = {quo_q[QuoW-2:0], !trial[RootW]};

endmodule

// ----- sim/thick_line_quad_expander_test.sv -----
module thick_line_quad_expander_test;
  import tlqe_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tlqe_seg_if  seg_if ();
  tlqe_vert_if vert_if ();

  thick_line_quad_expander i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .seg_i  (seg_if.sink),
    .vert_o (vert_if.source)
  );

  // Free-running clock, period 2.
  always #1 clk_i = ~clk_i;

  seg_t  pending_segs[$];
  vert_t expected_corners[$];
  logic [CountW-1:0] corner_count = '0;
  int unsigned mismatches = 0;
  int unsigned segs_sent = 0;
  int unsigned corners_seen = 0;
  int unsigned short_segs = 0;
  int unsigned seg_gap;
  int unsigned vert_stall;
  bit          stim_done = 1'b0;
  logic        seg_taken;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [CoordW-1:0] clamp_coord(longint v);
    if (v > 64'sd8388607) return 24'h7FFFFF;
    if (v < -64'sd8388608) return 24'h800000;
    return v[CoordW-1:0];
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res;
    longint unsigned bit_pos;
    res = 0;
    bit_pos = 64'd1 << 62;
    while (bit_pos > v) bit_pos >>= 2;
    while (bit_pos != 0) begin
      if (v >= res + bit_pos) begin
        v -= res + bit_pos;
        res = (res >> 1) + bit_pos;
      end else begin
        res >>= 1;
      end
      bit_pos >>= 2;
    end
    return res;
  endfunction

  function automatic longint div_nearest(longint num, longint unsigned den);
    longint unsigned mag;
    longint unsigned quo;
    mag = num < 0 ? longint'(-num) : longint'(num);
    quo = (mag + den / 2) / den;
    return num < 0 ? -longint'(quo) : longint'(quo);
  endfunction

  // Work out the four corners of one segment and queue them.
  task automatic predict_quad(input seg_t s);
    longint sx, sy, ex, ey, dx, dy, w, nx, ny;
    longint unsigned sq, len;
    longint px[4], py[4];
    vert_t v;
    sx = longint'($signed(s.start_x));
    sy = longint'($signed(s.start_y));
    ex = longint'($signed(s.end_x));
    ey = longint'($signed(s.end_y));
    w  = longint'({1'b0, s.line_width});
    dx = ex - sx;
    dy = ey - sy;
    sq = dx * dx + dy * dy;
    if (sq == 0) begin
      short_segs++;
      return;
    end
    len = root_floor(sq << 14);
    nx = div_nearest(-dy * w * 64, len);
    ny = div_nearest(dx * w * 64, len);
    px[0] = sx + nx; py[0] = sy + ny;
    px[1] = ex + nx; py[1] = ey + ny;
    px[2] = ex - nx; py[2] = ey - ny;
    px[3] = sx - nx; py[3] = sy - ny;
    for (int k = 0; k < 4; k++) begin
      v.vert_x = clamp_coord(px[k]);
      v.vert_y = clamp_coord(py[k]);
      v.vert_color = s.packed_color;
      v.vertex_number = corner_count + CountW'(k);
      v.corner = 2'(k);
      v.last_corner = (k == 3);
      expected_corners.insert(expected_corners.size(), v);
    end
    corner_count += CountW'(4);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch on %s: got %h, expected %h", what, got, want);
    mismatches++;
  endtask

  function automatic seg_t make_seg(int sx, int sy, int ex, int ey, int w, int c);
    seg_t s;
    s.start_x = sx[23:0]; s.start_y = sy[23:0];
    s.end_x = ex[23:0]; s.end_y = ey[23:0];
    s.line_width = w[15:0]; s.packed_color = c;
    return s;
  endfunction

  function automatic logic [CoordW-1:0] rand_coord(int unsigned mode);
    if (mode == 0) return 24'($urandom());
    if (mode == 1) return 24'(int'($urandom_range(0, 8000)) - 4000);
    return $urandom_range(0, 1) ? 24'(24'h7FFFFF - $urandom_range(0, 300))
                                : 24'(24'h800000 + $urandom_range(0, 300));
  endfunction

  // Directed cases first, then random segments.
  initial begin
    seg_t s;
    int unsigned mode;
    pending_segs.insert(pending_segs.size(), make_seg(0, 0, 256, 0, 256, 32'h11223344));
    pending_segs.insert(pending_segs.size(), make_seg(0, 0, 0, 256, 512, 32'hFFFFFFFF));
    pending_segs.insert(pending_segs.size(), make_seg(100, 100, 100, 100, 256, 32'h0));
    pending_segs.insert(pending_segs.size(),
                        make_seg(-5, 7, -5, 7, 65535, 32'hA5A5A5A5));
    pending_segs.insert(pending_segs.size(),
                        make_seg(0, 0, 1, 0, 65535, 32'h5A5A5A5A));
    pending_segs.insert(pending_segs.size(), make_seg(0, 0, 0, 1, 65535, 32'h1));
    pending_segs.insert(pending_segs.size(),
                        make_seg(10, 20, 3000, -700, 0, 32'h80000000));
    pending_segs.insert(pending_segs.size(),
                        make_seg(-8388608, -8388608, 8388607, 8388607, 65535,
                                 32'hDEADBEEF));
    pending_segs.insert(pending_segs.size(),
                        make_seg(8388607, -8388608, -8388608, 8388607, 65535,
                                 32'h0F0F0F0F));
    pending_segs.insert(pending_segs.size(),
                        make_seg(8388607, 8388607, 8388607, 8388000, 65535,
                                 32'h12345678));
    pending_segs.insert(pending_segs.size(),
                        make_seg(-8388608, -8388608, -8388000, -8388608,
                                 65535, 32'h87654321));
    pending_segs.insert(pending_segs.size(),
                        make_seg(-8388608, 0, -8388608, 0, 0, 32'h0));
    pending_segs.insert(pending_segs.size(),
                        make_seg(8388607, 8388607, -8388608, -8388608, 1,
                                 32'hCAFEF00D));
    pending_segs.insert(pending_segs.size(), make_seg(0, 0, -3, 4, 128, 32'h7));
    for (int i = 0; i < 216; i++) begin
      mode = $urandom_range(0, 2);
      s.start_x = rand_coord(mode);
      s.start_y = rand_coord(mode);
      s.end_x = rand_coord(mode);
      s.end_y = rand_coord(mode);
      s.line_width = $urandom_range(0, 3) == 0 ? 16'($urandom()) :
                     16'($urandom_range(0, 4096));
      s.packed_color = $urandom();
      // Now and then a degenerate segment.
      if ($urandom_range(0, 19) == 0) begin
        s.end_x = s.start_x;
        s.end_y = s.start_y;
      end
      pending_segs.insert(pending_segs.size(), s);
    end
  end

  // Note a segment beat taken at the rising edge.
  always @(posedge clk_i) begin
    seg_taken <= rst_ni && seg_if.valid && seg_if.ready;
  end

  // Segment driver: inputs change on the falling edge.
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_if.valid <= 1'b0;
      seg_if.data <= '0;
      seg_gap = 0;
    end else begin
      if (seg_taken) begin
        predict_quad(seg_if.data);
        segs_sent++;
        void'(pending_segs.pop_front());
        seg_gap = pick_gap();
      end
      if (seg_gap > 0) begin
        seg_gap = seg_gap - 1;
        seg_if.valid <= 1'b0;
      end else if (pending_segs.size() > 0) begin
        seg_if.valid <= 1'b1;
        seg_if.data <= pending_segs[0];
      end else begin
        seg_if.valid <= 1'b0;
        stim_done <= 1'b1;
      end
    end
  end

  // Corner sink: ready stalls at random.
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vert_if.ready <= 1'b0;
      vert_stall <= 0;
    end else if (vert_stall > 0) begin
      vert_stall <= vert_stall - 1;
      vert_if.ready <= 1'b0;
    end else begin
      vert_if.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) vert_stall <= pick_gap();
    end
  end

  // Corner monitor: compare each accepted beat with the oldest expectation.
  always @(posedge clk_i) begin
    vert_t got;
    vert_t want;
    if (rst_ni && vert_if.valid && vert_if.ready) begin
      got = vert_if.data;
      corners_seen++;
      if (expected_corners.size() == 0) begin
        report_mismatch("unexpected beat", 64'(got.vertex_number), 64'd0);
      end else begin
        want = expected_corners.pop_front();
        if (got.vert_x !== want.vert_x)
          report_mismatch("vert_x", 64'(got.vert_x), 64'(want.vert_x));
        if (got.vert_y !== want.vert_y)
          report_mismatch("vert_y", 64'(got.vert_y), 64'(want.vert_y));
        if (got.vert_color !== want.vert_color)
          report_mismatch("vert_color", 64'(got.vert_color), 64'(want.vert_color));
        if (got.vertex_number !== want.vertex_number)
          report_mismatch("vertex_number", 64'(got.vertex_number),
                          64'(want.vertex_number));
        if (got.corner !== want.corner)
          report_mismatch("corner", 64'(got.corner), 64'(want.corner));
        if (got.last_corner !== want.last_corner)
          report_mismatch("last_corner", 64'(got.last_corner), 64'(want.last_corner));
      end
    end
  end

  // Reset, then wait for the stimulus to drain.
  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    wait (stim_done);
    while (expected_corners.size() > 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (expected_corners.size() > 0) mismatches++;
    $display("Sent %0d segments (%0d degenerate), checked %0d corner beats.",
             segs_sent, short_segs, corners_seen);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("Timeout with %0d corners outstanding.", expected_corners.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
